@@ sv/pli_pkg.sv @@
package pli_pkg;

   localparam int CAPACITY   = 16;
   localparam int ELEM_WIDTH = 32;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [MODE_W-1:0] MODE_ADD_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD_POS   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_REAR  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  removed_value;
      logic [LEN_W-1:0]    length;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                do_ins;
      logic                do_del;
      logic [IDX_W-1:0]    idx;
      logic [CNT_W-1:0]    held_in;
   } ctrl_type;

endpackage

@@ sv/pli_req_if.sv @@
interface pli_req_if
   import pli_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/pli_rsp_if.sv @@
interface pli_rsp_if
   import pli_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/pli_cell.sv @@
module pli_cell
   import pli_pkg::*;
(
   input  logic                  clock,
   input  cell_op_type           op,
   input  logic [ELEM_WIDTH-1:0] load_data,
   input  logic [ELEM_WIDTH-1:0] prev_data,
   input  logic [ELEM_WIDTH-1:0] next_data,
   output logic [ELEM_WIDTH-1:0] data
);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;

   always_comb begin
      case (op)
         CELL_LOAD:      data_in = load_data;
         CELL_FROM_PREV: data_in = prev_data;
         CELL_FROM_NEXT: data_in = next_data;
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ sv/pli_ctrl.sv @@
module pli_ctrl
   import pli_pkg::*;
(
   input  logic [MODE_W-1:0] mode,
   input  logic [POS_W-1:0]  position,
   input  logic [CNT_W-1:0]  held,
   output ctrl_type          ctrl
);

   localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);
   localparam logic [CMP_W-1:0] ONE_X = CMP_W'(1);

   logic [CMP_W-1:0] held_x;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] idx_x;

   assign held_x = CMP_W'(held);
   assign pos_x  = CMP_W'(position);

   always_comb begin
      ctrl.status = ST_OK;
      ctrl.do_ins = 1'b0;
      ctrl.do_del = 1'b0;
      idx_x       = '0;
      unique case (mode) inside
         MODE_ADD_FRONT, MODE_ADD_REAR: begin
            if (held_x >= CAP_X) begin
               ctrl.status = ST_FULL;
            end else begin
               ctrl.do_ins = 1'b1;
               idx_x       = (mode == MODE_ADD_FRONT) ? '0 : held_x;
            end
         end
         MODE_ADD_POS: begin
            // range is checked before fullness
            if (pos_x == '0 || pos_x > held_x + ONE_X) begin
               ctrl.status = ST_RANGE;
            end else if (held_x >= CAP_X) begin
               ctrl.status = ST_FULL;
            end else begin
               ctrl.do_ins = 1'b1;
               idx_x       = pos_x - ONE_X;
            end
         end
         MODE_DEL_FRONT, MODE_DEL_REAR: begin
            if (held_x == '0) begin
               ctrl.status = ST_UNDERFLOW;
            end else begin
               ctrl.do_del = 1'b1;
               idx_x       = (mode == MODE_DEL_FRONT) ? '0 : held_x - ONE_X;
            end
         end
         MODE_DEL_POS: begin
            if (pos_x == '0 || pos_x > held_x) begin
               ctrl.status = ST_RANGE;
            end else begin
               ctrl.do_del = 1'b1;
               idx_x       = pos_x - ONE_X;
            end
         end
         default: begin
            ctrl.status = ST_OK;
         end
      endcase
      ctrl.idx = idx_x[IDX_W-1:0];
      if (ctrl.do_ins) begin
         ctrl.held_in = held + CNT_W'(1);
      end else if (ctrl.do_del) begin
         ctrl.held_in = held - CNT_W'(1);
      end else begin
         ctrl.held_in = held;
      end
   end

endmodule

@@ sv/positional_list_insert_delete.sv @@
// Bounded ordered list held in a row of CAPACITY cells, cell 0 the front.
// Every request word (insert front/rear/before a position, delete
// front/rear/at a position) returns one response word with a status, the
// removed element and the new length. One request is taken per clock while the
// response side keeps up: all cells at or after the target position shift by
// one place toward the rear (insert) or the front (delete) in the same cycle,
// so the response appears in the cycle after the request is taken. The
// response sits in an output register, and a new request is taken while it is
// being read out; a response that is not taken stalls the request side.
module positional_list_insert_delete
   import pli_pkg::*;
(
   input logic clock,
   input logic reset,
   pli_req_if.sink   req,
   pli_rsp_if.source rsp
);

   logic [CNT_W-1:0] held_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_payload_ff;

   logic                  req_fire;
   ctrl_type              ctrl;
   logic [ELEM_WIDTH-1:0] elem_in;
   logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
   cell_op_type           cell_op [CAPACITY];
   rsp_type               rsp_payload_in;

   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;
   assign elem_in   = ELEM_WIDTH'(req.payload.value);

   pli_ctrl u_ctrl (
      .mode     (req.payload.mode),
      .position (req.payload.position),
      .held     (held_ff),
      .ctrl     (ctrl)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] prev_data;
      logic [ELEM_WIDTH-1:0] next_data;

      if (i == 0) begin : g_front
         assign prev_data = elem_in;
      end else begin : g_inner_prev
         assign prev_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_rear
         assign next_data = '0;
      end else begin : g_inner_next
         assign next_data = cell_data[i+1];
      end

      always_comb begin
         cell_op[i] = CELL_HOLD;
         if (req_fire && ctrl.do_ins) begin
            if (IDX_W'(i) == ctrl.idx) begin
               cell_op[i] = CELL_LOAD;
            end else if (IDX_W'(i) > ctrl.idx) begin
               cell_op[i] = CELL_FROM_PREV;
            end
         end else if (req_fire && ctrl.do_del) begin
            if (IDX_W'(i) >= ctrl.idx) begin
               cell_op[i] = CELL_FROM_NEXT;
            end
         end
      end

      pli_cell u_cell (
         .clock     (clock),
         .op        (cell_op[i]),
         .load_data (elem_in),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   always_comb begin
      rsp_payload_in.status        = ctrl.status;
      rsp_payload_in.removed_value = ctrl.do_del ? VALUE_W'(cell_data[ctrl.idx]) : '0;
      rsp_payload_in.length        = LEN_W'(ctrl.held_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            held_ff        <= ctrl.held_in;
            rsp_valid_ff   <= 1'b1;
            rsp_payload_ff <= rsp_payload_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;

endmodule

@@ sv/pli_checker.sv @@
module pli_checker
   import pli_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // every accepted request word shows a response the next cycle
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.length <= LEN_W'(CAPACITY))
      else $error("length above capacity");

   a_fail_no_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.removed_value == '0)
      else $error("failed operation returned an element");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL |-> rsp_payload.length == LEN_W'(CAPACITY))
      else $error("full status with list not full");

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

@@ test/tb_positional_list_insert_delete.sv @@
`timescale 1ns / 1ps

import pli_pkg::*;

class list_scoreboard;
   logic [ELEM_WIDTH-1:0] elems[$];
   rsp_type               due_rsps[$];
   int                    errors;
   int                    checked;
   int                    mode_seen[8];
   int                    status_seen[4];

   function int held();
      return elems.size();
   endfunction

   function int pending();
      return due_rsps.size();
   endfunction

   function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // apply one accepted request word to the shadow list and queue its response
   function void note_request(req_type w);
      rsp_type               due;
      int                    n;
      int                    pos;
      logic [ELEM_WIDTH-1:0] v;
      n = elems.size();
      pos = int'(w.position);
      v = w.value[ELEM_WIDTH-1:0];
      due = '0;
      due.status = ST_OK;
      case (w.mode)
         MODE_ADD_FRONT, MODE_ADD_REAR: begin
            if (n >= CAPACITY) begin
               due.status = ST_FULL;
            end else if (w.mode == MODE_ADD_FRONT) begin
               elems.push_front(v);
            end else begin
               elems.push_back(v);
            end
         end
         MODE_ADD_POS: begin
            // position is checked before fullness
            if (pos < 1 || pos > n + 1) begin
               due.status = ST_RANGE;
            end else if (n >= CAPACITY) begin
               due.status = ST_FULL;
            end else begin
               elems.insert(pos - 1, v);
            end
         end
         MODE_DEL_FRONT: begin
            if (n == 0) begin
               due.status = ST_UNDERFLOW;
            end else begin
               due.removed_value = VALUE_W'(elems.pop_front());
            end
         end
         MODE_DEL_REAR: begin
            if (n == 0) begin
               due.status = ST_UNDERFLOW;
            end else begin
               due.removed_value = VALUE_W'(elems.pop_back());
            end
         end
         MODE_DEL_POS: begin
            if (pos < 1 || pos > n) begin
               due.status = ST_RANGE;
            end else begin
               due.removed_value = VALUE_W'(elems[pos - 1]);
               elems.delete(pos - 1);
            end
         end
         default: begin
         end
      endcase
      due.length = LEN_W'(elems.size());
      mode_seen[w.mode]++;
      due_rsps.push_back(due);
   endfunction

   function void check_response(rsp_type got);
      rsp_type due;
      string   msg;
      if (due_rsps.size() == 0) begin
         note_error($sformatf("unexpected response word: status %0d removed %h length %0d",
                              got.status, got.removed_value, got.length));
         return;
      end
      due = due_rsps.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got.status !== due.status || got.removed_value !== due.removed_value ||
          got.length !== due.length) begin
         msg = $sformatf("mismatch on response %0d: expected status %0d removed %h length %0d",
                         checked, due.status, due.removed_value, due.length);
         note_error($sformatf("%s, got status %0d removed %h length %0d",
                              msg, got.status, got.removed_value, got.length));
      end
   endfunction
endclass

module tb_positional_list_insert_delete;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int RANDOM_WORDS = 1500;
   localparam int HOLD_CYCLES  = 200;

   logic clock;
   logic reset;

   pli_req_if req_ch ();
   pli_rsp_if rsp_ch ();

   positional_list_insert_delete u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   list_scoreboard sb = new();

   bit calm;
   bit start_hold;
   int sent;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic req_type word_of(logic [MODE_W-1:0] m, logic [POS_W-1:0] p,
                                       logic [VALUE_W-1:0] v);
      req_type w;
      w.mode = m;
      w.position = p;
      w.value = v;
      return w;
   endfunction

   // mostly well-formed operations; insert-heavy while filling, delete-heavy while draining
   function automatic req_type pick_request(int n, bit filling);
      req_type w;
      int      r;
      bit      is_ins;
      r = $urandom_range(99);
      if (r < 3) begin
         w.mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_ADD_FRONT));
      end else if (r < (filling ? 80 : 25)) begin
         w.mode = MODE_W'($urandom_range(MODE_ADD_POS, MODE_ADD_FRONT));
      end else begin
         w.mode = MODE_W'($urandom_range(MODE_DEL_POS, MODE_DEL_FRONT));
      end
      is_ins = (w.mode == MODE_ADD_FRONT || w.mode == MODE_ADD_REAR || w.mode == MODE_ADD_POS);
      if ($urandom_range(99) < 12) begin
         w.position = POS_W'($urandom_range(31));
      end else if (is_ins) begin
         w.position = POS_W'($urandom_range(n + 1, 1));
      end else if (n > 0) begin
         w.position = POS_W'($urandom_range(n, 1));
      end else begin
         w.position = POS_W'($urandom_range(31));
      end
      case ($urandom_range(9))
         0: w.value = '0;
         1: w.value = '1;
         default: w.value = VALUE_W'($urandom);
      endcase
      return w;
   endfunction

   task automatic offer(input req_type w);
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(w);
      sent++;
      if (!calm && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // response side: random back-pressure plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_response(rsp_ch.payload);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (start_hold) begin
            start_hold = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
         end
      end
   end

   initial begin
      bit filling;
      int phase_left;
      int wait_cycles;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      calm = 1'b0;
      start_hold = 1'b0;
      sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list cases, then a few inserts, both spare modes and every kind of delete
      offer(word_of(MODE_DEL_FRONT, 5'd1, 32'h0));
      offer(word_of(MODE_DEL_REAR, 5'd1, 32'h0));
      offer(word_of(MODE_DEL_POS, 5'd1, 32'h0));
      offer(word_of(MODE_ADD_POS, 5'd0, 32'h1111_1111));
      offer(word_of(MODE_ADD_POS, 5'd2, 32'h2222_2222));
      offer(word_of(MODE_ADD_POS, 5'd1, 32'h0000_0000));
      offer(word_of(MODE_ADD_FRONT, 5'd0, 32'hffff_ffff));
      offer(word_of(MODE_ADD_REAR, 5'd31, 32'h1234_5678));
      offer(word_of(MODE_ADD_POS, 5'd4, 32'ha5a5_a5a5));
      offer(word_of(MODE_ADD_POS, 5'd2, 32'h5a5a_5a5a));
      offer(word_of(MODE_ADD_POS, 5'd31, 32'h3333_3333));
      offer(word_of(MODE_SPARE_LO, 5'd31, 32'hffff_ffff));
      offer(word_of(MODE_SPARE_HI, 5'd0, 32'h8000_0001));
      offer(word_of(MODE_DEL_POS, 5'd0, 32'h0));
      offer(word_of(MODE_DEL_POS, 5'd6, 32'h0));
      offer(word_of(MODE_DEL_POS, 5'd5, 32'h0));
      offer(word_of(MODE_DEL_POS, 5'd2, 32'h0));
      offer(word_of(MODE_DEL_FRONT, 5'd0, 32'h0));
      offer(word_of(MODE_DEL_REAR, 5'd0, 32'h0));
      offer(word_of(MODE_DEL_POS, 5'd1, 32'h0));
      offer(word_of(MODE_DEL_POS, 5'd31, 32'h0));

      filling = 1'b1;
      phase_left = $urandom_range(90, 30);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 700 && i < 1000);
         if (i == 400) begin
            start_hold = 1'b1;
         end
         if (phase_left == 0) begin
            filling = !filling;
            phase_left = $urandom_range(90, 30);
         end
         phase_left--;
         offer(pick_request(sb.held(), filling));
      end
      req_ch.valid <= 1'b0;

      wait_cycles = 0;
      while (sb.pending() > 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (sb.pending() > 0) begin
         $display("status: fail");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         $display("sent %0d request words, checked %0d responses (%0d errors)",
                  sent, sb.checked, sb.errors);
         $display("responses ok %0d, underflow %0d, out of range %0d, full %0d",
                  sb.status_seen[ST_OK], sb.status_seen[ST_UNDERFLOW],
                  sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL]);
         if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
         end else begin
            $display("status: fail");
         end
         $finish;
      end
   end

endmodule
